/* src/assert_macros.svh */
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define FPFA_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpfa assertion failed");

// next-cycle implication
`define FPFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpfa assertion failed");

`endif

/* src/fpfa_pkg.sv */
// constants, codes and control types of the partition fit allocator
package fpfa_pkg;

   localparam int MAX_HOLES = 32;
   localparam int IDX_W     = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
   localparam int CNT_W     = $clog2(MAX_HOLES + 1);

   localparam int CMD_W     = 2;
   localparam int SLOT_W    = 5;
   localparam int SIZE_W    = 16;
   localparam int TOTAL_W   = 21;
   localparam int MODE_W    = 2;
   localparam int COUNT_W   = 6;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // request commands
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // fit policies, anything else acts as first fit
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] REG_FIT_MODE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLE_COUNT = 1'd1;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic apply;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

/* src/fpfa_req_if.sv */
// request channel of the partition fit allocator
interface fpfa_req_if;
   logic                           valid;
   logic                           ready;
   logic [fpfa_pkg::CMD_W-1:0]     command;
   logic [fpfa_pkg::SLOT_W-1:0]    hole_slot;
   logic [fpfa_pkg::SIZE_W-1:0]    size_value;

   modport source (output valid, command, hole_slot, size_value, input ready);
   modport sink   (input valid, command, hole_slot, size_value, output ready);
endinterface

/* src/fpfa_rsp_if.sv */
// response channel of the partition fit allocator
interface fpfa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           placed;
   logic [fpfa_pkg::SLOT_W-1:0]    chosen_hole;
   logic [fpfa_pkg::SIZE_W-1:0]    leftover;
   logic [fpfa_pkg::TOTAL_W-1:0]   internal_total;
   logic [fpfa_pkg::TOTAL_W-1:0]   external_total;

   modport source (output valid, placed, chosen_hole, leftover, internal_total,
                   external_total, input ready);
   modport sink   (input valid, placed, chosen_hole, leftover, internal_total,
                   external_total, output ready);
endinterface

/* src/fixed_partition_fit_allocator.sv */
// top level of the fixed partition fit allocator
// a request is captured, load or clear is applied, the n active holes are scanned, and
//    the finish state fills the response register once it is free, n being hole_count
//    clamped to the table depth; one request is in flight, the scan reads one hole a cycle
// the response register frees the request side while a response waits to be taken
// reset: synchronous, clears config, used flags, loaded flags and the leftover sum;
//    holes never loaded read as size zero
module fixed_partition_fit_allocator (
   input  logic                                clock,
   input  logic                                reset,
   fpfa_req_if.sink                            req_ch,
   fpfa_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // command and status between sequencer and datapath
   fpfa_pkg::ctrl_cmd_type  cmd;
   fpfa_pkg::dp_status_type status;
   logic                    req_ready;

   // request is taken only between commands; one request in flight
   assign req_ch.ready = req_ready;

   // sequencer: capture, apply load or clear, scan the active holes, finish
   fpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: hole table, fit selection, totals and the response register
   fpfa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_command    (req_ch.command),
      .req_hole_slot  (req_ch.hole_slot),
      .req_size_value (req_ch.size_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_ch         (rsp_ch)
   );

endmodule

/* src/fpfa_ctrl.sv */
// sequencer of the partition fit allocator
`include "assert_macros.svh"

module fpfa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fpfa_pkg::dp_status_type status,
   output fpfa_pkg::ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_APPLY  = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // nothing is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FPFA_ASSERT(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))
   `FPFA_ASSERT_NEXT(a_capture_then_apply, clock, reset, cmd.capture, cmd.apply)

endmodule

/* src/fpfa_datapath.sv */
// hole table, scan unit, totals and response register
`include "assert_macros.svh"

module fpfa_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic [fpfa_pkg::CMD_W-1:0]             req_command,
   input  logic [fpfa_pkg::SLOT_W-1:0]            req_hole_slot,
   input  logic [fpfa_pkg::SIZE_W-1:0]            req_size_value,
   input  fpfa_pkg::ctrl_cmd_type                 cmd,
   output fpfa_pkg::dp_status_type                status,
   fpfa_rsp_if.source                             rsp_ch
);

   localparam int IW = fpfa_pkg::IDX_W;
   localparam int CW = fpfa_pkg::CNT_W;
   localparam int SW = fpfa_pkg::SIZE_W;
   localparam int TW = fpfa_pkg::TOTAL_W;
   localparam int NH = fpfa_pkg::MAX_HOLES;

   // configuration
   logic [fpfa_pkg::MODE_W-1:0]  fit_mode_ff, fit_mode_in;
   logic [fpfa_pkg::COUNT_W-1:0] hole_count_ff, hole_count_in;

   // hole table
   logic [SW-1:0]  sizes_ff [NH];
   logic [NH-1:0]  loaded_ff, loaded_in;
   logic [NH-1:0]  used_ff, used_in;
   logic [TW-1:0]  leftover_sum_ff, leftover_sum_in;

   // latched request
   logic [fpfa_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [fpfa_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [SW-1:0]               need_ff, need_in;

   // scan state
   logic [CW-1:0]  scan_idx_ff, scan_idx_in;
   logic           found_ff, found_in;
   logic [IW-1:0]  pick_idx_ff, pick_idx_in;
   logic [SW-1:0]  pick_size_ff, pick_size_in;
   logic [TW-1:0]  ext_acc_ff, ext_acc_in;

   // response register
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_placed_ff, rsp_placed_in;
   logic [fpfa_pkg::SLOT_W-1:0] rsp_hole_ff, rsp_hole_in;
   logic [SW-1:0]  rsp_left_ff, rsp_left_in;
   logic [TW-1:0]  rsp_int_ff, rsp_int_in;
   logic [TW-1:0]  rsp_ext_ff, rsp_ext_in;

   logic [CW-1:0]  active_n;
   logic [IW-1:0]  rd_idx;
   logic [IW-1:0]  wr_idx;
   logic           slot_ok;
   logic [SW-1:0]  rd_size;
   logic           rd_free;
   logic           take;
   logic           fits;
   logic [SW-1:0]  left;
   logic [TW:0]    sum_wide;
   logic [TW-1:0]  sum_sat;
   logic           size_we;

   // holes above the table depth are not there
   assign active_n = (int'(hole_count_ff) > NH) ? CW'(NH) : CW'(hole_count_ff);

   assign rd_idx  = scan_idx_ff[IW-1:0];
   assign rd_size = loaded_ff[rd_idx] ? sizes_ff[rd_idx] : '0;
   assign rd_free = !used_ff[rd_idx];

   assign wr_idx  = IW'(slot_ff);
   assign slot_ok = int'(slot_ff) < NH;
   assign size_we = cmd.apply && (cmd_ff == fpfa_pkg::CMD_LOAD) && slot_ok;

   always_comb begin
      case (fit_mode_ff)
         fpfa_pkg::FIT_BEST:
            take = rd_free && (rd_size >= need_ff) && (!found_ff || rd_size < pick_size_ff);
         fpfa_pkg::FIT_WORST:
            take = rd_free && (!found_ff || rd_size > pick_size_ff);
         default:
            take = rd_free && (rd_size >= need_ff) && !found_ff;
      endcase
   end

   // worst fit may have picked a hole that is still too small
   assign fits     = (cmd_ff == fpfa_pkg::CMD_ALLOC) && found_ff && (pick_size_ff >= need_ff);
   assign left     = pick_size_ff - need_ff;
   assign sum_wide = {1'b0, leftover_sum_ff} + (TW + 1)'(left);
   assign sum_sat  = (sum_wide > {1'b0, fpfa_pkg::TOTAL_MAX}) ? fpfa_pkg::TOTAL_MAX
                                                               : sum_wide[TW-1:0];

   always_comb begin
      fit_mode_in     = fit_mode_ff;
      hole_count_in   = hole_count_ff;
      loaded_in       = loaded_ff;
      used_in         = used_ff;
      leftover_sum_in = leftover_sum_ff;
      cmd_in          = cmd_ff;
      slot_in         = slot_ff;
      need_in         = need_ff;
      scan_idx_in     = scan_idx_ff;
      found_in        = found_ff;
      pick_idx_in     = pick_idx_ff;
      pick_size_in    = pick_size_ff;
      ext_acc_in      = ext_acc_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_placed_in   = rsp_placed_ff;
      rsp_hole_in     = rsp_hole_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_int_in      = rsp_int_ff;
      rsp_ext_in      = rsp_ext_ff;

      if (csr_we) begin
         case (csr_index)
            fpfa_pkg::REG_FIT_MODE:   fit_mode_in   = csr_wdata[fpfa_pkg::MODE_W-1:0];
            fpfa_pkg::REG_HOLE_COUNT: hole_count_in = csr_wdata[fpfa_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         cmd_in  = req_command;
         slot_in = req_hole_slot;
         need_in = req_size_value;
      end

      if (cmd.apply) begin
         scan_idx_in  = '0;
         found_in     = 1'b0;
         pick_idx_in  = '0;
         pick_size_in = '0;
         ext_acc_in   = '0;
         case (cmd_ff)
            fpfa_pkg::CMD_LOAD: begin
               if (slot_ok) begin
                  loaded_in[wr_idx] = 1'b1;
                  used_in[wr_idx]   = 1'b0;
               end
            end
            fpfa_pkg::CMD_CLEAR: begin
               used_in         = '0;
               leftover_sum_in = '0;
            end
            default: ;
         endcase
      end

      if (cmd.step) begin
         scan_idx_in = scan_idx_ff + CW'(1);
         if (rd_free) begin
            ext_acc_in = ext_acc_ff + TW'(rd_size);
         end
         if (take) begin
            found_in     = 1'b1;
            pick_idx_in  = rd_idx;
            pick_size_in = rd_size;
         end
      end

      if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_placed_in = fits;
         rsp_hole_in   = fits ? fpfa_pkg::SLOT_W'(pick_idx_ff) : '0;
         rsp_left_in   = fits ? left : '0;
         rsp_int_in    = fits ? sum_sat : leftover_sum_ff;
         rsp_ext_in    = fits ? (ext_acc_ff - TW'(pick_size_ff)) : ext_acc_ff;
         if (fits) begin
            used_in[pick_idx_ff] = 1'b1;
            leftover_sum_in      = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff     <= fpfa_pkg::FIT_FIRST;
         hole_count_ff   <= '0;
         loaded_ff       <= '0;
         used_ff         <= '0;
         leftover_sum_ff <= '0;
         scan_idx_ff     <= '0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         fit_mode_ff     <= fit_mode_in;
         hole_count_ff   <= hole_count_in;
         loaded_ff       <= loaded_in;
         used_ff         <= used_in;
         leftover_sum_ff <= leftover_sum_in;
         scan_idx_ff     <= scan_idx_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      need_ff       <= need_in;
      pick_idx_ff   <= pick_idx_in;
      pick_size_ff  <= pick_size_in;
      ext_acc_ff    <= ext_acc_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_hole_ff   <= rsp_hole_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_int_ff    <= rsp_int_in;
      rsp_ext_ff    <= rsp_ext_in;
      if (size_we) begin
         sizes_ff[wr_idx] <= need_ff;
      end
   end

   assign status.scan_done = scan_idx_ff >= active_n;
   assign status.out_free  = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.placed         = rsp_placed_ff;
   assign rsp_ch.chosen_hole    = rsp_hole_ff;
   assign rsp_ch.leftover       = rsp_left_ff;
   assign rsp_ch.internal_total = rsp_int_ff;
   assign rsp_ch.external_total = rsp_ext_ff;

   `FPFA_ASSERT(a_scan_in_range, clock, reset, 1'b1, scan_idx_ff <= CW'(NH))
   `FPFA_ASSERT(a_pick_active, clock, reset, cmd.finish && fits, pick_idx_ff < active_n)
   `FPFA_ASSERT_NEXT(a_mark_used, clock, reset, cmd.finish && fits, used_ff[pick_idx_ff])

endmodule

/* sim/fixed_partition_fit_allocator_tb.sv */
// self-checking testbench for the fixed partition fit allocator
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_tb;
   import fpfa_pkg::*;

   // codes the package leaves unnamed
   localparam logic [CMD_W-1:0]  CMD_SPARE = 2'd3;
   localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 48;
   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SLOT_W-1:0] hole_slot;
      logic [SIZE_W-1:0] size_value;
   } alloc_request_type;

   typedef struct packed {
      logic               placed;
      logic [SLOT_W-1:0]  chosen_hole;
      logic [SIZE_W-1:0]  leftover;
      logic [TOTAL_W-1:0] internal_total;
      logic [TOTAL_W-1:0] external_total;
   } alloc_outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fpfa_req_if req_ch ();
   fpfa_rsp_if rsp_ch ();

   fixed_partition_fit_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns period, first rising edge at 2 ns
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // request traffic between the stimulus and the driver
   alloc_request_type requests_to_send[$];
   alloc_outcome_type outcomes_due[$];
   int requests_queued = 0;
   int requests_accepted = 0;
   logic req_taken = 1'b0;

   // sizes the stimulus has loaded, used to aim allocations at real holes
   logic [SIZE_W-1:0] planned_size [MAX_HOLES];

   // predictor state: hole table, used flags, fragmentation sum and registers
   logic [SIZE_W-1:0]    model_size [MAX_HOLES];
   logic [MAX_HOLES-1:0] model_used;
   logic [TOTAL_W-1:0]   model_frag;
   logic [MODE_W-1:0]    model_mode;
   logic [COUNT_W-1:0]   model_count;

   // run statistics
   int error_count = 0;
   int responses_checked = 0;
   int placements = 0;
   int refusals = 0;
   int settings_used = 0;

   // long receiver hold-off
   logic hold_request = 1'b0;
   logic hold_off = 1'b0;

   // sender burst state
   int tx_burst = 1;
   int tx_gap = 0;
   alloc_request_type tx_item;

   // receiver stall state
   int rx_tick = 0;
   int rx_style = 0;
   int rx_run = 0;
   logic rx_go;

   int cycles_run = 0;
   alloc_outcome_type due;

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t ns, response %0d: %s", $time, responses_checked, msg);
   endtask

   function automatic logic [TOTAL_W-1:0] sat_sum(input logic [TOTAL_W-1:0] a,
                                                  input logic [TOTAL_W-1:0] b);
      logic [TOTAL_W:0] s;
      s = a + b;
      return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
   endfunction

   // applies one request to the predictor state and returns its response
   function automatic alloc_outcome_type predict_outcome(input alloc_request_type rq);
      alloc_outcome_type res;
      int active;
      int pick;
      res = '0;
      // counts above the table depth act as the full table
      active = (model_count > MAX_HOLES) ? MAX_HOLES : int'(model_count);
      case (rq.command)
         CMD_LOAD: begin
            // a reload frees the hole but leaves the fragmentation sum alone
            model_size[rq.hole_slot] = rq.size_value;
            model_used[rq.hole_slot] = 1'b0;
         end
         CMD_ALLOC: begin
            pick = -1;
            for (int i = 0; i < active; i++) begin
               if (!model_used[i]) begin
                  if (model_mode == FIT_BEST) begin
                     if (model_size[i] >= rq.size_value &&
                         (pick < 0 || model_size[i] < model_size[pick]))
                        pick = i;
                  end else if (model_mode == FIT_WORST) begin
                     // largest free hole, whether it fits or not
                     if (pick < 0 || model_size[i] > model_size[pick])
                        pick = i;
                  end else if (pick < 0 && model_size[i] >= rq.size_value) begin
                     // first fit, also for the spare mode code
                     pick = i;
                  end
               end
            end
            if (pick >= 0 && model_size[pick] >= rq.size_value) begin
               res.placed = 1'b1;
               res.chosen_hole = pick[SLOT_W-1:0];
               res.leftover = model_size[pick] - rq.size_value;
               model_used[pick] = 1'b1;
               model_frag = sat_sum(model_frag, TOTAL_W'(res.leftover));
            end
         end
         CMD_CLEAR: begin
            model_used = '0;
            model_frag = '0;
         end
         default: ;
      endcase
      res.internal_total = model_frag;
      for (int i = 0; i < active; i++)
         if (!model_used[i])
            res.external_total = sat_sum(res.external_total, TOTAL_W'(model_size[i]));
      return res;
   endfunction

   // predictor and checker, both on the rising edge
   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (reset) begin
         for (int i = 0; i < MAX_HOLES; i++)
            model_size[i] = '0;
         model_used = '0;
         model_frag = '0;
         model_mode = FIT_FIRST;
         model_count = '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FIT_MODE:   model_mode = csr_wdata[MODE_W-1:0];
               REG_HOLE_COUNT: model_count = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         // compare before pushing: a response never belongs to a request of the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcomes_due.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               due = outcomes_due.pop_front();
               if (rsp_ch.placed !== due.placed)
                  report_mismatch($sformatf("placed is %b, expected %b",
                                            rsp_ch.placed, due.placed));
               if (rsp_ch.chosen_hole !== due.chosen_hole)
                  report_mismatch($sformatf("chosen_hole is %0d, expected %0d",
                                            rsp_ch.chosen_hole, due.chosen_hole));
               if (rsp_ch.leftover !== due.leftover)
                  report_mismatch($sformatf("leftover is %0d, expected %0d",
                                            rsp_ch.leftover, due.leftover));
               if (rsp_ch.internal_total !== due.internal_total)
                  report_mismatch($sformatf("internal_total is %0d, expected %0d",
                                            rsp_ch.internal_total, due.internal_total));
               if (rsp_ch.external_total !== due.external_total)
                  report_mismatch($sformatf("external_total is %0d, expected %0d",
                                            rsp_ch.external_total, due.external_total));
               responses_checked++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            tx_item.command = req_ch.command;
            tx_item.hole_slot = req_ch.hole_slot;
            tx_item.size_value = req_ch.size_value;
            outcomes_due.push_back(predict_outcome(tx_item));
            if (req_ch.command == CMD_ALLOC) begin
               if (outcomes_due[$].placed)
                  placements++;
               else
                  refusals++;
            end
            requests_accepted++;
         end
      end
   end

   // driver: bursts of requests with random gaps, an offered request is held until taken
   always @(negedge clock) begin
      if (!req_ch.valid || req_taken) begin
         if (tx_gap > 0 || requests_to_send.size() == 0) begin
            if (tx_gap > 0)
               tx_gap--;
            req_ch.valid <= 1'b0;
         end else begin
            tx_item = requests_to_send.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.command <= tx_item.command;
            req_ch.hole_slot <= tx_item.hole_slot;
            req_ch.size_value <= tx_item.size_value;
            tx_burst--;
            if (tx_burst <= 0) begin
               tx_burst = $urandom_range(1, 40);
               // a third of the bursts run straight into the next one
               tx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // receiver: runs one of four stall styles, redrawn at random as rx_tick advances
   always @(negedge clock) begin
      rx_tick++;
      if (rx_tick % 300 == 0)
         rx_style = $urandom_range(0, 3);
      case (rx_style)
         0: rx_go = 1'b1;
         1: rx_go = 1'($urandom_range(0, 1));
         2: rx_go = (rx_tick % 7) > 2;
         default: begin
            // occasional long stalls
            if (rx_run > 0) begin
               rx_run--;
               rx_go = 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               rx_run = $urandom_range(5, 60);
               rx_go = 1'b0;
            end else begin
               rx_go = 1'b1;
            end
         end
      endcase
      rsp_ch.ready <= rx_go && !hold_off;
   end

   // one long hold-off so that the block backs up and stalls its request side
   initial begin
      wait (hold_request);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles_run, outcomes_due.size());
         $display("fixed_partition_fit_allocator: mismatch");
         $finish;
      end
   end

   task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                input logic [SIZE_W-1:0] size);
      alloc_request_type rq;
      rq.command = cmd;
      rq.hole_slot = slot;
      rq.size_value = size;
      requests_to_send.push_back(rq);
      requests_queued++;
      if (cmd == CMD_LOAD)
         planned_size[slot] = size;
   endtask

   // idle: every queued request taken and every response back
   task automatic wait_until_idle();
      while (requests_accepted != requests_queued || outcomes_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // mode word may carry junk above the two mode bits
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] mode_word,
                                input logic [COUNT_W-1:0] count);
      wait_until_idle();
      write_csr(REG_FIT_MODE, mode_word);
      write_csr(REG_HOLE_COUNT, count);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [SIZE_W-1:0] pick_hole_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return SIZE_W'($urandom);
         // narrow range gives plenty of ties
         default: return SIZE_W'($urandom_range(0, 48));
      endcase
   endfunction

   // process sizes mostly aimed at a loaded hole: exact, one too big or a little smaller
   function automatic logic [SIZE_W-1:0] pick_process_size(input int active);
      logic [SIZE_W-1:0] base;
      if (active == 0 || $urandom_range(0, 4) == 0)
         return pick_hole_size();
      base = planned_size[$urandom_range(0, active - 1)];
      case ($urandom_range(0, 3))
         0: return base;
         1: return (base == '1) ? base : base + 1'b1;
         default: return (base < 3) ? '0 : base - SIZE_W'($urandom_range(0, 3));
      endcase
   endfunction

   // one random setting: clear, fill most active holes, then a mixed stream
   task automatic run_episode(input logic [COUNT_W-1:0] count, input int length);
      int active;
      int kind;
      apply_setting(CSR_DATA_W'($urandom_range(0, 63)), count);
      active = (count > MAX_HOLES) ? MAX_HOLES : int'(count);
      queue_request(CMD_CLEAR, SLOT_W'($urandom), SIZE_W'($urandom));
      for (int i = 0; i < active; i++)
         if ($urandom_range(0, 3) != 0)
            queue_request(CMD_LOAD, SLOT_W'(i), pick_hole_size());
      repeat (length) begin
         kind = $urandom_range(0, 19);
         if (kind < 10)
            queue_request(CMD_ALLOC, SLOT_W'($urandom), pick_process_size(active));
         else if (kind < 14 && active > 0)
            queue_request(CMD_LOAD, SLOT_W'($urandom_range(0, active - 1)), pick_hole_size());
         else if (kind < 15)
            queue_request(CMD_CLEAR, SLOT_W'($urandom), SIZE_W'($urandom));
         else if (kind < 16)
            queue_request(CMD_SPARE, SLOT_W'($urandom), SIZE_W'($urandom));
         else if (kind < 18)
            // any slot, including holes beyond the count
            queue_request(CMD_LOAD, SLOT_W'($urandom), pick_hole_size());
         else
            queue_request(CMD_ALLOC, SLOT_W'($urandom), SIZE_W'($urandom));
      end
   endtask

   task automatic pick_episode_count(output logic [COUNT_W-1:0] count);
      case ($urandom_range(0, 9))
         0: count = '0;
         1: count = COUNT_W'(MAX_HOLES);
         2: count = COUNT_W'($urandom_range(MAX_HOLES + 1, 63));
         default: count = COUNT_W'($urandom_range(1, 12));
      endcase
   endtask

   initial begin
      logic [COUNT_W-1:0] count;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.command = '0;
      req_ch.hole_slot = '0;
      req_ch.size_value = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < MAX_HOLES; i++)
         planned_size[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: first fit over the full table
      apply_setting(CSR_DATA_W'(FIT_FIRST), COUNT_W'(MAX_HOLES));
      queue_request(CMD_ALLOC, 5'd0, 16'd0);        // zero-size holes fit a zero process
      queue_request(CMD_CLEAR, 5'd0, 16'd0);
      queue_request(CMD_LOAD, 5'd31, 16'hFFFF);
      queue_request(CMD_LOAD, 5'd0, 16'd100);
      queue_request(CMD_LOAD, 5'd5, 16'd300);
      queue_request(CMD_LOAD, 5'd7, 16'd300);       // tie with hole 5
      queue_request(CMD_ALLOC, 5'd0, 16'hFFFF);
      queue_request(CMD_ALLOC, 5'd0, 16'd200);
      queue_request(CMD_ALLOC, 5'd0, 16'hFFFF);     // nothing left that fits
      queue_request(CMD_LOAD, 5'd31, 16'd5);        // reload of a used hole
      queue_request(CMD_SPARE, 5'd31, 16'hFFFF);
      queue_request(CMD_CLEAR, 5'd0, 16'd0);

      // best fit, ties to the lowest index
      apply_setting(CSR_DATA_W'(FIT_BEST), COUNT_W'(MAX_HOLES));
      queue_request(CMD_ALLOC, 5'd0, 16'd250);
      queue_request(CMD_ALLOC, 5'd0, 16'd250);
      queue_request(CMD_ALLOC, 5'd0, 16'd1);
      queue_request(CMD_ALLOC, 5'd0, 16'd0);

      // worst fit, junk above the mode bits
      apply_setting({4'b1010, FIT_WORST}, COUNT_W'(MAX_HOLES));
      queue_request(CMD_CLEAR, 5'd0, 16'd0);
      queue_request(CMD_ALLOC, 5'd0, 16'd50);
      queue_request(CMD_ALLOC, 5'd0, 16'd400);      // largest free hole too small

      // spare mode code with the count above the table depth
      apply_setting({4'b0101, FIT_SPARE}, 6'd63);
      queue_request(CMD_ALLOC, 5'd0, 16'd10);

      // count cuts off hole 7
      apply_setting({4'b0101, FIT_SPARE}, 6'd6);
      queue_request(CMD_ALLOC, 5'd0, 16'd200);

      // empty table window
      apply_setting(CSR_DATA_W'(FIT_FIRST), 6'd0);
      queue_request(CMD_ALLOC, 5'd0, 16'd0);
      queue_request(CMD_LOAD, 5'd3, 16'd7);

      // random settings and streams
      for (int e = 0; e < 30; e++) begin
         pick_episode_count(count);
         run_episode(count, 50);
         if (e == 4)
            hold_request = 1'b1;
         if (e == 15) begin
            // reload and refill one big hole until the fragmentation sum saturates
            apply_setting(CSR_DATA_W'(FIT_FIRST), 6'd1);
            repeat (34) begin
               queue_request(CMD_LOAD, 5'd0, 16'hFFFF);
               queue_request(CMD_ALLOC, SLOT_W'($urandom), 16'd0);
            end
            queue_request(CMD_ALLOC, 5'd0, 16'd0);
            queue_request(CMD_CLEAR, 5'd0, 16'd0);
         end
      end

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests under %0d register settings, %0d placed, %0d refused",
               requests_accepted, settings_used, placements, refusals);
      $display("%0d responses checked, %0d field errors", responses_checked, error_count);
      if (error_count == 0)
         $display("fixed_partition_fit_allocator: match");
      else
         $display("fixed_partition_fit_allocator: mismatch");
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/fpfa_pkg.sv
src/fpfa_req_if.sv
src/fpfa_rsp_if.sv
src/fpfa_ctrl.sv
src/fpfa_datapath.sv
src/fixed_partition_fit_allocator.sv
sim/fixed_partition_fit_allocator_tb.sv
